// ----- design/wps_pkg.sv -----
// ----------------------------------------------------------------------------
// Weld pulse sequencer package
// Shared widths, codes, reset values and the structures passed between the
// configuration block, the sequencing core and the output buffer.
// ----------------------------------------------------------------------------
package wps_pkg;

    localparam int SETTING_W  = 9;
    localparam int TIMER_W    = 16;
    localparam int ADVANCE_W  = 6;
    localparam int STEP_W     = 8;
    localparam int SEG_LEN_W  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Phase codes
    localparam logic [1:0] PH_BOOT  = 2'd0;
    localparam logic [1:0] PH_READY = 2'd1;
    localparam logic [1:0] PH_FIRE  = 2'd2;
    localparam logic [1:0] PH_COOL  = 2'd3;

    // Weld segments
    localparam logic [1:0] SEG_PRE   = 2'd0;
    localparam logic [1:0] SEG_PAUSE = 2'd1;
    localparam logic [1:0] SEG_MAIN  = 2'd2;
    localparam logic [1:0] SEG_TAIL  = 2'd3;

    // Setting selection
    localparam logic [1:0] SEL_PRE   = 2'd0;
    localparam logic [1:0] SEL_PAUSE = 2'd1;
    localparam logic [1:0] SEL_MAIN  = 2'd2;

    // Request types
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_CMD  = 1'b1;

    // Command bytes
    localparam logic [7:0] CMD_SEL_FIRST = 8'h31;
    localparam logic [7:0] CMD_SEL_LAST  = 8'h33;
    localparam logic [7:0] CMD_INC       = 8'h69;
    localparam logic [7:0] CMD_DEC       = 8'h64;
    localparam logic [7:0] CMD_EDIT      = 8'h65;
    localparam logic [7:0] CMD_FIRE      = 8'h21;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd5;

    // Reset values
    localparam logic [ADVANCE_W-1:0] RST_ADVANCE  = 6'd5;
    localparam logic [TIMER_W-1:0]   RST_COOLDOWN = 16'd5000;
    localparam logic [TIMER_W-1:0]   RST_BOOT     = 16'd1000;
    localparam logic [SETTING_W-1:0] RST_MIN      = 9'd10;
    localparam logic [SETTING_W-1:0] RST_MAX      = 9'd400;
    localparam logic [STEP_W-1:0]    RST_STEP     = 8'd10;
    localparam logic [SETTING_W-1:0] RST_PRE      = 9'd30;
    localparam logic [SETTING_W-1:0] RST_PAUSE    = 9'd10;
    localparam logic [SETTING_W-1:0] RST_MAIN     = 9'd130;

    typedef logic [SETTING_W-1:0] setting_t;

    typedef struct packed {
        logic [ADVANCE_W-1:0] advance;
        logic [TIMER_W-1:0]   cooldown;
        setting_t             min_val;
        setting_t             max_val;
        logic [STEP_W-1:0]    step;
    } wps_cfg_t;

    typedef struct packed {
        logic               load;
        logic [TIMER_W-1:0] value;
    } wps_boot_load_t;

    typedef struct packed {
        logic       relay_on;
        logic [1:0] phase;
        logic [1:0] selected_index;
        logic       edit_mode;
        setting_t   pre_pulse;
        setting_t   pause;
        setting_t   main_pulse;
    } wps_result_t;

endpackage

// ----- design/wps_cfg.sv -----
// ----------------------------------------------------------------------------
// Weld pulse sequencer configuration registers
// Holds the configuration registers and passes a boot delay write on to the
// core, which only needs it to reload its boot timer.
// ----------------------------------------------------------------------------
module wps_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output wps_pkg::wps_cfg_t                cfg,
    output wps_pkg::wps_boot_load_t          boot_load
);

    logic [wps_pkg::ADVANCE_W-1:0] advance_reg;
    logic [wps_pkg::TIMER_W-1:0]   cooldown_reg;
    wps_pkg::setting_t             min_reg;
    wps_pkg::setting_t             max_reg;
    logic [wps_pkg::STEP_W-1:0]    step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            advance_reg    <= wps_pkg::RST_ADVANCE;
            cooldown_reg   <= wps_pkg::RST_COOLDOWN;
            min_reg        <= wps_pkg::RST_MIN;
            max_reg        <= wps_pkg::RST_MAX;
            step_reg       <= wps_pkg::RST_STEP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wps_pkg::CFG_ADVANCE:  advance_reg    <= cfg_wdata[wps_pkg::ADVANCE_W-1:0];
                wps_pkg::CFG_COOLDOWN: cooldown_reg   <= cfg_wdata[wps_pkg::TIMER_W-1:0];
                wps_pkg::CFG_MIN:      min_reg        <= cfg_wdata[wps_pkg::SETTING_W-1:0];
                wps_pkg::CFG_MAX:      max_reg        <= cfg_wdata[wps_pkg::SETTING_W-1:0];
                wps_pkg::CFG_STEP:     step_reg       <= cfg_wdata[wps_pkg::STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.advance    = advance_reg;
    assign cfg.cooldown   = cooldown_reg;
    assign cfg.min_val    = min_reg;
    assign cfg.max_val    = max_reg;
    assign cfg.step       = step_reg;

    // While booting and taking no request, the core reloads its boot timer with the same write.
    assign boot_load.load  = cfg_we && (cfg_index == wps_pkg::CFG_BOOT);
    assign boot_load.value = cfg_wdata[wps_pkg::TIMER_W-1:0];

endmodule

// ----- design/wps_core.sv -----
// ----------------------------------------------------------------------------
// Weld pulse sequencer core
// Settings, command decoding and the weld segment timer, updated once for
// each accepted request and by a boot delay write while booting.
// ----------------------------------------------------------------------------
module wps_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_accept,
    input  logic                          req_type,
    input  logic [7:0]                    cmd_byte,
    input  wps_pkg::wps_cfg_t             cfg,
    input  wps_pkg::wps_boot_load_t       boot_load,
    output wps_pkg::wps_result_t          result
);

    logic [1:0]                  phase_reg, phase_next;
    logic [1:0]                  segment_reg, segment_next;
    logic [wps_pkg::TIMER_W-1:0] timer_reg, timer_next;
    wps_pkg::setting_t           latched_reg [3];
    wps_pkg::setting_t           latched_next [3];
    wps_pkg::setting_t           setting_reg [3];
    wps_pkg::setting_t           setting_next [3];
    logic [1:0]                  selected_reg, selected_next;
    logic                        edit_reg, edit_next;

    wps_pkg::setting_t           sel_value;
    logic [1:0]                  sel_idx;
    wps_pkg::setting_t           inc_value;
    wps_pkg::setting_t           dec_value;
    logic                        fire_go;
    wps_pkg::setting_t           lat_eff [3];
    logic [wps_pkg::SEG_LEN_W-1:0] seg_len [4];
    logic [2:0]                  enter_start;
    logic                        enter_found;
    logic [1:0]                  enter_seg;
    logic [wps_pkg::SEG_LEN_W-1:0] enter_len;

    // Sum or difference is held in eleven signed bits, then clamped low first.
    function automatic wps_pkg::setting_t clamp_setting(
        input logic signed [10:0] v,
        input wps_pkg::setting_t  lo,
        input wps_pkg::setting_t  hi
    );
        logic signed [10:0] lo_s;
        logic signed [10:0] hi_s;
        wps_pkg::setting_t  res;
        lo_s = $signed({2'b00, lo});
        hi_s = $signed({2'b00, hi});
        if (v < lo_s)
            res = lo;
        else if (v > hi_s)
            res = hi;
        else
            res = v[wps_pkg::SETTING_W-1:0];
        return res;
    endfunction

    always_comb
    begin
        unique case (selected_reg)
            wps_pkg::SEL_PAUSE: sel_idx = wps_pkg::SEL_PAUSE;
            wps_pkg::SEL_MAIN:  sel_idx = wps_pkg::SEL_MAIN;
            default:            sel_idx = wps_pkg::SEL_PRE;
        endcase
    end

    assign sel_value = setting_reg[sel_idx];
    assign inc_value = clamp_setting($signed({2'b00, sel_value}) + $signed({3'b000, cfg.step}),
                                     cfg.min_val, cfg.max_val);
    assign dec_value = clamp_setting($signed({2'b00, sel_value}) - $signed({3'b000, cfg.step}),
                                     cfg.min_val, cfg.max_val);

    assign fire_go = req_accept && (req_type == wps_pkg::REQ_CMD)
                     && (cmd_byte == wps_pkg::CMD_FIRE) && (phase_reg == wps_pkg::PH_READY);

    // A fire uses the freshly latched durations for its first segment search.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (fire_go)
                lat_eff[i] = (setting_reg[i] > {3'b000, cfg.advance})
                             ? setting_reg[i] - {3'b000, cfg.advance} : '0;
            else
                lat_eff[i] = latched_reg[i];
        end
    end

    assign seg_len[0] = {1'b0, lat_eff[0]};
    assign seg_len[1] = {3'b000, cfg.advance, 1'b0} + {1'b0, lat_eff[1]};
    assign seg_len[2] = {1'b0, lat_eff[2]};
    assign seg_len[3] = {4'b0000, cfg.advance};

    assign enter_start = fire_go ? 3'd0 : ({1'b0, segment_reg} + 3'd1);

    // Lowest non-empty segment at or after the start; empty ones take no tick.
    always_comb
    begin
        enter_found = 1'b0;
        enter_seg   = wps_pkg::SEG_PRE;
        enter_len   = '0;
        for (int i = 3; i >= 0; i--)
        begin
            if ((3'(i) >= enter_start) && (seg_len[i] != '0))
            begin
                enter_found = 1'b1;
                enter_seg   = 2'(i);
                enter_len   = seg_len[i];
            end
        end
    end

    always_comb
    begin
        logic do_enter;
        do_enter       = 1'b0;
        phase_next     = phase_reg;
        segment_next   = segment_reg;
        timer_next     = timer_reg;
        selected_next  = selected_reg;
        edit_next      = edit_reg;
        for (int i = 0; i < 3; i++)
        begin
            latched_next[i] = latched_reg[i];
            setting_next[i] = setting_reg[i];
        end

        if (req_accept)
        begin
            if (req_type == wps_pkg::REQ_TICK)
            begin
                unique case (phase_reg)
                    wps_pkg::PH_BOOT, wps_pkg::PH_COOL:
                    begin
                        if (timer_reg > 16'd1)
                            timer_next = timer_reg - 16'd1;
                        else
                        begin
                            phase_next = wps_pkg::PH_READY;
                            timer_next = '0;
                        end
                    end
                    wps_pkg::PH_FIRE:
                    begin
                        if (timer_reg > 16'd1)
                            timer_next = timer_reg - 16'd1;
                        else
                            do_enter = 1'b1;
                    end
                    wps_pkg::PH_READY:
                    begin
                    end
                endcase
            end
            else
            begin
                priority if ((cmd_byte >= wps_pkg::CMD_SEL_FIRST)
                             && (cmd_byte <= wps_pkg::CMD_SEL_LAST))
                begin
                    selected_next = 2'(cmd_byte - wps_pkg::CMD_SEL_FIRST);
                    edit_next     = 1'b0;
                end
                else if (cmd_byte == wps_pkg::CMD_INC)
                    setting_next[sel_idx] = inc_value;
                else if (cmd_byte == wps_pkg::CMD_DEC)
                    setting_next[sel_idx] = dec_value;
                else if (cmd_byte == wps_pkg::CMD_EDIT)
                    edit_next = ~edit_reg;
                else if (fire_go)
                begin
                    for (int i = 0; i < 3; i++)
                        latched_next[i] = lat_eff[i];
                    do_enter = 1'b1;
                end
            end
        end
        else if (boot_load.load && (phase_reg == wps_pkg::PH_BOOT))
            timer_next = boot_load.value;

        if (do_enter)
        begin
            if (enter_found)
            begin
                phase_next   = wps_pkg::PH_FIRE;
                segment_next = enter_seg;
                timer_next   = {6'b000000, enter_len};
            end
            else
            begin
                segment_next = wps_pkg::SEG_PRE;
                if (cfg.cooldown != '0)
                begin
                    phase_next = wps_pkg::PH_COOL;
                    timer_next = cfg.cooldown;
                end
                else
                begin
                    phase_next = wps_pkg::PH_READY;
                    timer_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= wps_pkg::PH_BOOT;
            segment_reg    <= wps_pkg::SEG_PRE;
            timer_reg      <= wps_pkg::RST_BOOT;
            latched_reg[0] <= '0;
            latched_reg[1] <= '0;
            latched_reg[2] <= '0;
            setting_reg[0] <= wps_pkg::RST_PRE;
            setting_reg[1] <= wps_pkg::RST_PAUSE;
            setting_reg[2] <= wps_pkg::RST_MAIN;
            selected_reg   <= wps_pkg::SEL_PRE;
            edit_reg       <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            segment_reg  <= segment_next;
            timer_reg    <= timer_next;
            selected_reg <= selected_next;
            edit_reg     <= edit_next;
            for (int i = 0; i < 3; i++)
            begin
                latched_reg[i] <= latched_next[i];
                setting_reg[i] <= setting_next[i];
            end
        end
    end

    // The result shows the state after the request.
    assign result.relay_on       = (phase_next == wps_pkg::PH_FIRE)
                                   && ((segment_next == wps_pkg::SEG_PRE)
                                       || (segment_next == wps_pkg::SEG_MAIN));
    assign result.phase          = phase_next;
    assign result.selected_index = selected_next;
    assign result.edit_mode      = edit_next;
    assign result.pre_pulse      = setting_next[0];
    assign result.pause          = setting_next[1];
    assign result.main_pulse     = setting_next[2];

`ifndef SYNTHESIS
    // Outside a weld the segment index rests at the pre-pulse.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != wps_pkg::PH_FIRE) |-> (segment_reg == wps_pkg::SEG_PRE))
        else $error("segment index not cleared outside a weld");

    // A ready block has no time left to run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == wps_pkg::PH_READY) |-> (timer_reg == '0))
        else $error("timer running while ready");

    // An empty segment is never entered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == wps_pkg::PH_FIRE) |-> (timer_reg != '0))
        else $error("weld segment with zero length");

    // A fire request while ready leaves the ready phase unless the cool-down is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire_go |=> (phase_reg != wps_pkg::PH_READY || $past(cfg.cooldown) == '0))
        else $error("fire request did not start a weld");
`endif

endmodule

// ----- design/wps_out_buf.sv -----
// ----------------------------------------------------------------------------
// Weld pulse sequencer output buffer
// Result register with one skid entry so that a request is taken while a
// finished result still waits.
// ----------------------------------------------------------------------------
module wps_out_buf
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  wps_pkg::wps_result_t   push_data,
    input  logic                   out_stall,
    output logic                   out_valid,
    output wps_pkg::wps_result_t   out_data,
    output logic                   full
);

    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    wps_pkg::wps_result_t  out_data_reg;
    wps_pkg::wps_result_t  skid_data_reg;
    logic                  pop;

    assign pop = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (pop)
                    skid_valid_reg <= 1'b0;
            end
            else if (push && out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;

            if (pop)
                out_valid_reg <= skid_valid_reg || push;
            else if (push)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (push)
                out_data_reg <= push_data;
        end
        else if (push && !out_valid_reg)
            out_data_reg <= push_data;

        if (push && out_valid_reg && !pop && !skid_valid_reg)
            skid_data_reg <= push_data;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign full      = skid_valid_reg;

`ifndef SYNTHESIS
    // The skid entry is only ever behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result with no result in front");
`endif

endmodule

// ----- design/weld_pulse_sequencer.sv -----
// ----------------------------------------------------------------------------
// Weld pulse sequencer
// Spot-weld pulse timing from millisecond ticks and command bytes.
// ----------------------------------------------------------------------------
// One result, the state after a request (a tick or a command byte), is registered
// in the result register or, while a result still waits, in the skid entry; a
// request can be taken every cycle while in_stall is low. Requests are handled in
// one pass through the core logic into its state registers. Up to two results can
// wait for the receiver (result register plus one skid entry); in_stall rises only
// when both are full. Configuration writes take effect at the next edge.
module weld_pulse_sequencer
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 req_type,
    input  logic [7:0]                           cmd_byte,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 relay_on,
    output logic [1:0]                           phase,
    output logic [1:0]                           selected_index,
    output logic                                 edit_mode,
    output logic [wps_pkg::SETTING_W-1:0]        pre_pulse_ms,
    output logic [wps_pkg::SETTING_W-1:0]        pause_ms,
    output logic [wps_pkg::SETTING_W-1:0]        main_pulse_ms,
    input  logic                                 cfg_we,
    input  logic [wps_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wps_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    wps_pkg::wps_cfg_t        cfg;
    wps_pkg::wps_boot_load_t  boot_load;
    wps_pkg::wps_result_t     core_result;
    wps_pkg::wps_result_t     out_data;
    logic                     buf_full;
    logic                     req_accept;

    assign in_stall   = buf_full;
    assign req_accept = in_valid && !buf_full;

    wps_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .boot_load (boot_load)
    );

    wps_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_accept (req_accept),
        .req_type   (req_type),
        .cmd_byte   (cmd_byte),
        .cfg        (cfg),
        .boot_load  (boot_load),
        .result     (core_result)
    );

    wps_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_accept),
        .push_data (core_result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .full      (buf_full)
    );

    assign relay_on       = out_data.relay_on;
    assign phase          = out_data.phase;
    assign selected_index = out_data.selected_index;
    assign edit_mode      = out_data.edit_mode;
    assign pre_pulse_ms   = out_data.pre_pulse;
    assign pause_ms       = out_data.pause;
    assign main_pulse_ms  = out_data.main_pulse;

endmodule

// ----- bench/tb_weld_pulse_sequencer.sv -----
// ----------------------------------------------------------------------------
// Weld pulse sequencer testbench
// Sends millisecond ticks and command bytes through the request channel,
// keeps its own model of the settings, weld segments and timers, and checks
// every status result field by field. It runs a directed opening, phases of
// random weld sequences under changing idling and register settings, a
// back-pressure phase and weld attempts with the widest advance and the
// longest cool-down.
// ----------------------------------------------------------------------------
module tb_weld_pulse_sequencer;
    import wps_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_LEN      = 40;
    localparam int HOLD_PERIOD   = 60;
    localparam int PHASE_ITEMS   = 200;
    localparam int MAX_REPORTS   = 50;

    typedef struct packed {
        logic       kind;
        logic [7:0] code;
    } request_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic                  req_type  = REQ_TICK;
    logic [7:0]            cmd_byte  = 8'h00;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  relay_on;
    logic [1:0]            phase;
    logic [1:0]            selected_index;
    logic                  edit_mode;
    setting_t              pre_pulse_ms;
    setting_t              pause_ms;
    setting_t              main_pulse_ms;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ADVANCE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    weld_pulse_sequencer uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .cmd_byte       (cmd_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .relay_on       (relay_on),
        .phase          (phase),
        .selected_index (selected_index),
        .edit_mode      (edit_mode),
        .pre_pulse_ms   (pre_pulse_ms),
        .pause_ms       (pause_ms),
        .main_pulse_ms  (main_pulse_ms),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    request_t    request_queue[$];
    wps_result_t awaited_status[$];
    request_t    next_request;
    wps_result_t want;

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    bit hold_mode       = 1'b0;
    int hold_count      = 0;

    int cycle_count     = 0;
    int mismatches      = 0;
    int requests_taken  = 0;
    int results_checked = 0;
    int welds_started   = 0;
    int relay_results   = 0;
    int input_stalls    = 0;
    int queued_items    = 0;

    // Model of the sequencer
    logic [1:0]          seq_phase;
    logic [1:0]          seq_segment;
    logic [TIMER_W-1:0]  seq_timer;
    setting_t            seq_latched[3];
    setting_t            seq_setting[3];
    logic [1:0]          seq_selected;
    logic                seq_edit;
    logic [ADVANCE_W-1:0] lim_advance;
    logic [TIMER_W-1:0]  lim_cooldown;
    logic [TIMER_W-1:0]  lim_boot;
    setting_t            lim_min;
    setting_t            lim_max;
    logic [STEP_W-1:0]   lim_step;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic reset_sequencer_model();
        lim_advance  = RST_ADVANCE;
        lim_cooldown = RST_COOLDOWN;
        lim_boot     = RST_BOOT;
        lim_min      = RST_MIN;
        lim_max      = RST_MAX;
        lim_step     = RST_STEP;
        seq_phase    = PH_BOOT;
        seq_segment  = SEG_PRE;
        seq_timer    = RST_BOOT;
        seq_latched  = '{default: '0};
        seq_setting  = '{RST_PRE, RST_PAUSE, RST_MAIN};
        seq_selected = SEL_PRE;
        seq_edit     = 1'b0;
    endtask

    function automatic int segment_ticks(int seg);
        case (seg)
            0: return int'(seq_latched[0]);
            1: return 2 * int'(lim_advance) + int'(seq_latched[1]);
            2: return int'(seq_latched[2]);
            default: return int'(lim_advance);
        endcase
    endfunction

    // Zero-length segments are passed over without using up a tick.
    task automatic enter_weld_segment(int seg);
        int len;
        while (seg < 4)
        begin
            len = segment_ticks(seg);
            if (len != 0)
            begin
                seq_phase   = PH_FIRE;
                seq_segment = seg[1:0];
                seq_timer   = len[TIMER_W-1:0];
                return;
            end
            seg++;
        end
        seq_segment = SEG_PRE;
        if (lim_cooldown != 0)
        begin
            seq_phase = PH_COOL;
            seq_timer = lim_cooldown;
        end
        else
        begin
            seq_phase = PH_READY;
            seq_timer = '0;
        end
    endtask

    // The lower bound is tested first, so it wins when min is above max.
    function automatic setting_t clamp_setting(int v);
        if (v < int'(lim_min))
            return lim_min;
        if (v > int'(lim_max))
            return lim_max;
        return v[SETTING_W-1:0];
    endfunction

    task automatic apply_request(request_t r);
        int sel;
        if (r.kind == REQ_TICK)
        begin
            case (seq_phase)
                PH_BOOT, PH_COOL:
                    if (seq_timer > 1)
                        seq_timer--;
                    else
                    begin
                        seq_phase = PH_READY;
                        seq_timer = '0;
                    end
                PH_FIRE:
                    if (seq_timer > 1)
                        seq_timer--;
                    else
                        enter_weld_segment(int'(seq_segment) + 1);
                default: ;
            endcase
        end
        else
        begin
            sel = int'(seq_selected) % 3;
            if (r.code >= CMD_SEL_FIRST && r.code <= CMD_SEL_LAST)
            begin
                seq_selected = 2'(r.code - CMD_SEL_FIRST);
                seq_edit     = 1'b0;
            end
            else if (r.code == CMD_INC)
                seq_setting[sel] = clamp_setting(int'(seq_setting[sel]) + int'(lim_step));
            else if (r.code == CMD_DEC)
                seq_setting[sel] = clamp_setting(int'(seq_setting[sel]) - int'(lim_step));
            else if (r.code == CMD_EDIT)
                seq_edit = ~seq_edit;
            else if (r.code == CMD_FIRE && seq_phase == PH_READY)
            begin
                for (int i = 0; i < 3; i++)
                    seq_latched[i] = (seq_setting[i] > lim_advance) ?
                                     setting_t'(seq_setting[i] - lim_advance) : '0;
                welds_started++;
                enter_weld_segment(0);
            end
        end
    endtask

    function automatic wps_result_t sequencer_status();
        wps_result_t s;
        s.relay_on       = (seq_phase == PH_FIRE) &&
                           (seq_segment == SEG_PRE || seq_segment == SEG_MAIN);
        s.phase          = seq_phase;
        s.selected_index = seq_selected;
        s.edit_mode      = seq_edit;
        s.pre_pulse      = seq_setting[0];
        s.pause          = seq_setting[1];
        s.main_pulse     = seq_setting[2];
        return s;
    endfunction

    task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_ADVANCE:  lim_advance  = val[ADVANCE_W-1:0];
            CFG_COOLDOWN: lim_cooldown = val;
            CFG_BOOT:
            begin
                lim_boot = val;
                if (seq_phase == PH_BOOT)
                    seq_timer = lim_boot;
            end
            CFG_MIN:      lim_min  = val[SETTING_W-1:0];
            CFG_MAX:      lim_max  = val[SETTING_W-1:0];
            CFG_STEP:     lim_step = val[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int expected);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, expected);
    endtask

    // Request driver: a stalled request is held unchanged until taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (request_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                next_request = request_queue.pop_front();
                in_valid <= 1'b1;
                req_type <= next_request.kind;
                cmd_byte <= next_request.code;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Long receiver hold-offs, timed in their own counter.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_count <= 0;
        else if (hold_mode)
            hold_count <= (hold_count == HOLD_PERIOD - 1) ? 0 : hold_count + 1;
        else
            hold_count <= 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= (hold_mode && hold_count < HOLD_LEN) ||
                         ($urandom_range(99) < stall_pct);
    end

    // Monitor: register writes, accepted requests and accepted results.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            reset_sequencer_model();
        else
        begin
            if (cfg_we)
                apply_register(cfg_index, cfg_wdata);
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (awaited_status.size() == 0)
                    report_mismatch("result with nothing outstanding", 1, 0);
                else
                begin
                    want = awaited_status.pop_front();
                    if (relay_on != want.relay_on)
                        report_mismatch("relay_on", relay_on, want.relay_on);
                    if (phase != want.phase)
                        report_mismatch("phase", phase, want.phase);
                    if (selected_index != want.selected_index)
                        report_mismatch("selected_index", selected_index, want.selected_index);
                    if (edit_mode != want.edit_mode)
                        report_mismatch("edit_mode", edit_mode, want.edit_mode);
                    if (pre_pulse_ms != want.pre_pulse)
                        report_mismatch("pre_pulse_ms", pre_pulse_ms, want.pre_pulse);
                    if (pause_ms != want.pause)
                        report_mismatch("pause_ms", pause_ms, want.pause);
                    if (main_pulse_ms != want.main_pulse)
                        report_mismatch("main_pulse_ms", main_pulse_ms, want.main_pulse);
                    if (want.relay_on)
                        relay_results++;
                end
            end
            if (in_valid && in_stall)
                input_stalls++;
            if (in_valid && !in_stall)
            begin
                requests_taken++;
                apply_request('{req_type, cmd_byte});
                awaited_status.push_back(sequencer_status());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run timed out after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic write_small_limits();
        write_reg(CFG_ADVANCE,  16'($urandom_range(0, 4)));
        write_reg(CFG_COOLDOWN, 16'($urandom_range(0, 12)));
        write_reg(CFG_BOOT,     16'($urandom_range(0, 65535)));
        write_reg(CFG_MIN,      16'($urandom_range(0, 8)));
        write_reg(CFG_MAX,      16'($urandom_range(4, 30)));
        write_reg(CFG_STEP,     16'($urandom_range(1, 9)));
    endtask

    task automatic wait_until_idle();
        do
            @(negedge clk);
        while (request_queue.size() != 0 || in_valid || awaited_status.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic queue_command(logic [7:0] code);
        request_queue.push_back('{REQ_CMD, code});
        queued_items++;
    endtask

    task automatic queue_ticks(int n);
        for (int i = 0; i < n; i++)
        begin
            // The byte rides along with a tick and must be ignored.
            request_queue.push_back('{REQ_TICK, 8'($urandom_range(0, 255))});
            queued_items++;
        end
    endtask

    function automatic logic [7:0] random_edit();
        case ($urandom_range(0, 7))
            0, 1: return 8'(CMD_SEL_FIRST + $urandom_range(0, 2));
            2, 3: return CMD_INC;
            4, 5: return CMD_DEC;
            6:    return CMD_EDIT;
            default: return $urandom_range(0, 1) ? 8'(CMD_SEL_FIRST - 1) : 8'(CMD_SEL_LAST + 1);
        endcase
    endfunction

    // Mostly complete welds with random edits around them; the rest is noise.
    task automatic queue_random_traffic(int items);
        int target;
        target = queued_items + items;
        while (queued_items < target)
        begin
            if ($urandom_range(99) < 75)
            begin
                repeat ($urandom_range(0, 4)) queue_command(random_edit());
                queue_command(CMD_FIRE);
                queue_ticks($urandom_range(2, 60));
                if ($urandom_range(99) < 25)
                begin
                    queue_command(random_edit());
                    queue_command(CMD_FIRE);
                    queue_ticks($urandom_range(1, 40));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    if ($urandom_range(0, 1))
                        queue_ticks(1);
                    else
                        queue_command(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening limits: zero advance, cool-down and boot delay, widest clamp.
        write_reg(CFG_ADVANCE,  16'd0);
        write_reg(CFG_COOLDOWN, 16'd0);
        write_reg(CFG_BOOT,     16'd0);
        write_reg(CFG_MIN,      16'd0);
        write_reg(CFG_MAX,      16'd511);
        write_reg(CFG_STEP,     16'd255);

        queue_command(CMD_SEL_FIRST + 8'd1);
        queue_command(CMD_EDIT);
        queue_command(CMD_FIRE);
        queue_command(8'h00);
        queue_command(8'hFF);
        queue_ticks(2);
        queue_command(CMD_DEC);
        queue_command(CMD_SEL_FIRST);
        queue_command(CMD_DEC);
        queue_command(CMD_SEL_LAST);
        queue_command(CMD_DEC);
        queue_command(CMD_FIRE);
        queue_command(CMD_INC);
        queue_command(CMD_INC);
        queue_command(CMD_INC);
        queue_command(CMD_DEC);
        queue_command(CMD_DEC);
        queue_command(CMD_FIRE);
        queue_command(CMD_FIRE);
        queue_ticks(1);
        queue_command(CMD_EDIT);
        queue_command(CMD_SEL_FIRST - 8'd1);
        queue_command(CMD_SEL_LAST + 8'd1);
        wait_until_idle();

        // Minimum above maximum, smallest step.
        write_reg(CFG_MIN,  16'd511);
        write_reg(CFG_MAX,  16'd0);
        write_reg(CFG_STEP, 16'd1);
        queue_command(CMD_SEL_FIRST + 8'd1);
        queue_command(CMD_INC);
        queue_command(CMD_INC);
        queue_command(CMD_INC);
        queue_command(CMD_DEC);
        queue_command(CMD_SEL_FIRST);
        queue_command(CMD_INC);
        wait_until_idle();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 0;
                end
                1:
                begin
                    sender_idle_pct = 57;
                    stall_pct       = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 57;
                end
                default:
                begin
                    sender_idle_pct = 24;
                    stall_pct       = 24;
                end
            endcase
            write_small_limits();
            queue_random_traffic(PHASE_ITEMS);
            wait_until_idle();
        end

        // The receiver holds off long enough for the block to stall its input;
        // half way through, the sender waits until every result is back.
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_mode       = 1'b1;
        write_small_limits();
        queue_random_traffic(PHASE_ITEMS / 2);
        wait_until_idle();
        queue_random_traffic(PHASE_ITEMS / 2);
        wait_until_idle();
        hold_mode = 1'b0;

        // Widest advance and longest cool-down; every setting is first pulled
        // below the advance so that a new weld has only its gaps.
        write_reg(CFG_ADVANCE,  16'd63);
        write_reg(CFG_COOLDOWN, 16'd65535);
        write_reg(CFG_BOOT,     16'd65535);
        write_reg(CFG_MIN,      16'd10);
        write_reg(CFG_MAX,      16'd30);
        write_reg(CFG_STEP,     16'd255);
        queue_command(CMD_SEL_FIRST);
        queue_command(CMD_DEC);
        queue_command(CMD_SEL_FIRST + 8'd1);
        queue_command(CMD_DEC);
        queue_command(CMD_SEL_LAST);
        queue_command(CMD_DEC);
        repeat (3)
        begin
            queue_command(CMD_FIRE);
            queue_ticks(50);
        end
        wait_until_idle();
        repeat (5) @(posedge clk);

        $display("Checked %0d results from %0d requests; %0d welds started, %0d relay-on",
                 results_checked, requests_taken, welds_started, relay_results);
        $display("Input stalled for %0d cycles under receiver hold-off and random idling",
                 input_stalls);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/wps_pkg.sv
design/wps_cfg.sv
design/wps_core.sv
design/wps_out_buf.sv
design/weld_pulse_sequencer.sv
bench/tb_weld_pulse_sequencer.sv
